// ===== rtl/mpae_pkg.sv =====
// shared constants, types and elaboration-time trig tables for the platform angle estimator
// depends on nothing; used by mpae_atan_lane and marker_platform_angle_estimator_core
`default_nettype none
package mpae_pkg;

    localparam int CoordW   = 11;
    localparam int TabW     = 48;
    localparam int TabDepth = 128;
    localparam int DegW     = 7;
    localparam int AngW     = 9;
    localparam int NMark    = 4;
    localparam int NSearch  = 7;
    localparam int CfgIdxW  = 3;

    localparam logic [AngW-1:0] TriOffRst  = 9'd219;
    localparam logic [AngW-1:0] SqOffRst   = 9'd45;
    localparam logic [AngW-1:0] HexOffRst  = 9'd315;
    localparam logic [AngW-1:0] CircOffRst = 9'd135;

    localparam logic [CfgIdxW-1:0] RegTriOff  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegSqOff   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegHexOff  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCircOff = 3'd3;

    localparam logic [DegW-1:0] DegLimit = 7'd90;
    localparam logic [DegW-1:0] DegHalf  = 7'd45;

    localparam real Pi     = 3.14159265358979323846;
    localparam real DegRad = Pi / 180.0;

    // reciprocal factorials for the sine and cosine series
    localparam real InvF2  = 1.0 / 2.0;
    localparam real InvF3  = 1.0 / 6.0;
    localparam real InvF4  = 1.0 / 24.0;
    localparam real InvF5  = 1.0 / 120.0;
    localparam real InvF6  = 1.0 / 720.0;
    localparam real InvF7  = 1.0 / 5040.0;
    localparam real InvF8  = 1.0 / 40320.0;
    localparam real InvF9  = 1.0 / 362880.0;
    localparam real InvF10 = 1.0 / 3628800.0;
    localparam real InvF11 = 1.0 / 39916800.0;
    localparam real InvF12 = 1.0 / 479001600.0;
    localparam real InvF13 = 1.0 / 6227020800.0;
    localparam real InvF14 = 1.0 / 87178291200.0;
    localparam real InvF15 = 1.0 / 1307674368000.0;
    localparam real InvF16 = 1.0 / 20922789888000.0;
    localparam real InvF17 = 1.0 / 355687428096000.0;
    localparam real InvF18 = 1.0 / 6402373705728000.0;
    localparam real InvF19 = 1.0 / 121645100408832000.0;
    localparam real InvF20 = 1.0 / 2432902008176640000.0;

    typedef logic [TabW-1:0] t_tab [0:TabDepth-1];

    // per-marker sign and size flags carried alongside the search
    typedef struct packed {
        logic [NMark-1:0] dx_neg;
        logic [NMark-1:0] dx_zero;
        logic [NMark-1:0] dy_neg;
        logic [NMark-1:0] dy_zero;
        logic [NMark-1:0] diag;
        logic [NMark-1:0] mask;
        logic             ok;
    } t_side;

    // sin or cos of whole degrees, unsigned at scale 2^-48, zero past 89
    function automatic t_tab trig_tab(input bit want_cos);
        t_tab tab;
        real  x;
        real  x2;
        real  v;
        real  rem;
        int   hi;
        int   lo;
        for (int d = 0; d < TabDepth; d++) begin
            tab[d] = '0;
            if (d < 90) begin
                x  = d * DegRad;
                x2 = x * x;
                if (want_cos) begin
                    v = 1.0 - x2 * (InvF2 - x2 * (InvF4 - x2 * (InvF6 - x2 * (InvF8
                        - x2 * (InvF10 - x2 * (InvF12 - x2 * (InvF14 - x2 * (InvF16
                        - x2 * (InvF18 - x2 * InvF20)))))))));
                end else begin
                    v = x * (1.0 - x2 * (InvF3 - x2 * (InvF5 - x2 * (InvF7 - x2 * (InvF9
                        - x2 * (InvF11 - x2 * (InvF13 - x2 * (InvF15 - x2 * (InvF17
                        - x2 * InvF19)))))))));
                end
                if (v >= 1.0) begin
                    tab[d] = '1;
                end else if (v > 0.0) begin
                    hi  = $rtoi(v * 16777216.0);
                    rem = v * 16777216.0 - hi;
                    lo  = $rtoi(rem * 16777216.0);
                    tab[d] = {hi[23:0], lo[23:0]};
                end
            end
        end
        return tab;
    endfunction

    localparam t_tab SinTab = trig_tab(1'b0);
    localparam t_tab CosTab = trig_tab(1'b1);

endpackage
`default_nettype wire

// ===== rtl/mpae_atan_lane.sv =====
// seven-stage binary search for floor(atan(ay/ax)) in whole degrees, one marker
// depends on mpae_pkg (sin/cos tables, widths)
`default_nettype none
module mpae_atan_lane (
    input  wire                              i_clk,
    input  wire [mpae_pkg::NSearch-1:0]      i_en,
    input  wire [mpae_pkg::CoordW-1:0]       i_ax,
    input  wire [mpae_pkg::CoordW-1:0]       i_ay,
    output logic [mpae_pkg::DegW-1:0]        o_deg
);

    logic [mpae_pkg::CoordW-1:0] r_ax [mpae_pkg::NSearch];
    logic [mpae_pkg::CoordW-1:0] r_ay [mpae_pkg::NSearch];
    logic [mpae_pkg::DegW-1:0]   r_t  [mpae_pkg::NSearch];

    for (genvar j = 0; j < mpae_pkg::NSearch; j++) begin : g_step
        logic [mpae_pkg::CoordW-1:0]             ax;
        logic [mpae_pkg::CoordW-1:0]             ay;
        logic [mpae_pkg::DegW-1:0]               t;
        logic [mpae_pkg::DegW-1:0]               cand;
        logic [mpae_pkg::CoordW+mpae_pkg::TabW-1:0] lhs;
        logic [mpae_pkg::CoordW+mpae_pkg::TabW-1:0] rhs;
        logic                                    hit;
        logic [mpae_pkg::DegW-1:0]               n_t;

        if (j == 0) begin : g_first
            assign ax = i_ax;
            assign ay = i_ay;
            assign t  = '0;
        end else begin : g_next
            assign ax = r_ax[j-1];
            assign ay = r_ay[j-1];
            assign t  = r_t[j-1];
        end

        always_comb begin
            cand = t | mpae_pkg::DegW'(1 << (mpae_pkg::NSearch - 1 - j));
            lhs  = ay * mpae_pkg::CosTab[cand];
            rhs  = ax * mpae_pkg::SinTab[cand];
            // at 45 degrees the test is exact on the coordinates
            if (cand >= mpae_pkg::DegLimit) begin
                hit = 1'b0;
            end else if (cand == mpae_pkg::DegHalf) begin
                hit = (ay >= ax);
            end else begin
                hit = (lhs >= rhs);
            end
            n_t = hit ? cand : t;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_ax[j] <= ax;
                r_ay[j] <= ay;
                r_t[j]  <= n_t;
            end
        end
    end

    assign o_deg = r_t[mpae_pkg::NSearch-1];

endmodule
`default_nettype wire

// ===== rtl/marker_platform_angle_estimator_core.sv =====
// top level of the platform angle estimator: stream ports, offset registers, pipeline
// depends on mpae_pkg and mpae_atan_lane
`default_nettype none
// one frame (platform center plus up to four marker centers) enters per transaction and
// one result leaves per transaction, in order. the pipeline takes a new transaction every
// cycle while stage 0 is ready, and it has twelve register stages; the first is loaded by
// the edge that accepts a frame, and its result is presented on the master side from stage
// 11. stage 0 forms the offsets from the center, stages 1 to 7 run a per-marker binary
// search over a whole-degree sin/cos table (one table probe and two multiplies by table
// entries per step), then one stage each for bearing and offset removal, min/max and
// count, wrapped sum, and the divide and fold.
// each stage holds its transaction until the next one frees, so a stalled output only
// blocks input once every stage is full. offset registers are written through the cfg
// channel (always ready); indexes 4 and up are ignored. write them only while no
// transaction is in flight.
module marker_platform_angle_estimator_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // tdata: center_x, center_y, tri_x, tri_y, sq_x, sq_y, hex_x, hex_y, circ_x, circ_y
    input  wire  [111:0] i_s_tdata,
    // tuser: center_present, marker_mask[3:0]
    input  wire  [4:0]   i_s_tuser,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // tdata: platform_angle (signed 9 bits), zero padded
    output logic [15:0]  o_m_tdata,
    // tuser: angle_valid
    output logic         o_m_tuser,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [mpae_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire  [mpae_pkg::AngW-1:0]    i_cfg_data
);

    localparam int NStage = 12;
    localparam int SBear  = 8;
    localparam int SMinMx = 9;
    localparam int SSum   = 10;
    localparam int SOut   = 11;
    localparam int CW     = mpae_pkg::CoordW;

    // offset registers
    logic [mpae_pkg::AngW-1:0] r_off [mpae_pkg::NMark];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0] <= mpae_pkg::TriOffRst;
            r_off[1] <= mpae_pkg::SqOffRst;
            r_off[2] <= mpae_pkg::HexOffRst;
            r_off[3] <= mpae_pkg::CircOffRst;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mpae_pkg::RegTriOff)  r_off[0] <= i_cfg_data;
            if (i_cfg_index == mpae_pkg::RegSqOff)   r_off[1] <= i_cfg_data;
            if (i_cfg_index == mpae_pkg::RegHexOff)  r_off[2] <= i_cfg_data;
            if (i_cfg_index == mpae_pkg::RegCircOff) r_off[3] <= i_cfg_data;
        end
    end

    // stage valid bits and per-stage ready chain
    logic [NStage-1:0] r_vld;
    logic [NStage:0]   rdy;

    always_comb begin
        rdy[NStage] = i_m_tready;
        for (int k = NStage - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NStage; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_s_tready = rdy[0];

    // stage 0: offsets from the center, magnitudes and signs
    logic [CW-1:0]      cx;
    logic [CW-1:0]      cy;
    logic [CW-1:0]      mkx  [mpae_pkg::NMark];
    logic [CW-1:0]      mky  [mpae_pkg::NMark];
    logic signed [CW:0] dx   [mpae_pkg::NMark];
    logic signed [CW:0] dy   [mpae_pkg::NMark];
    logic [CW-1:0]      n_ax [mpae_pkg::NMark];
    logic [CW-1:0]      n_ay [mpae_pkg::NMark];
    mpae_pkg::t_side    n_side;

    logic [CW-1:0]   r0_ax [mpae_pkg::NMark];
    logic [CW-1:0]   r0_ay [mpae_pkg::NMark];
    mpae_pkg::t_side r_side [SBear];

    always_comb begin
        cx = i_s_tdata[CW-1:0];
        cy = i_s_tdata[2*CW-1:CW];
        n_side = '0;
        for (int m = 0; m < mpae_pkg::NMark; m++) begin
            mkx[m] = i_s_tdata[(2+2*m)*CW +: CW];
            mky[m] = i_s_tdata[(3+2*m)*CW +: CW];
            dx[m]  = $signed({1'b0, mkx[m]}) - $signed({1'b0, cx});
            dy[m]  = $signed({1'b0, mky[m]}) - $signed({1'b0, cy});
            n_ax[m] = dx[m][CW] ? CW'(-dx[m]) : dx[m][CW-1:0];
            n_ay[m] = dy[m][CW] ? CW'(-dy[m]) : dy[m][CW-1:0];
            n_side.dx_neg[m]  = dx[m][CW];
            n_side.dx_zero[m] = (dx[m] == '0);
            n_side.dy_neg[m]  = dy[m][CW];
            n_side.dy_zero[m] = (dy[m] == '0);
            n_side.diag[m]    = (n_ax[m] == n_ay[m]);
        end
        n_side.mask = i_s_tuser[4:1];
        n_side.ok   = i_s_tuser[0] && (i_s_tuser[4:1] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_ax     <= n_ax;
            r0_ay     <= n_ay;
            r_side[0] <= n_side;
        end
        for (int k = 1; k < SBear; k++) begin
            if (rdy[k]) r_side[k] <= r_side[k-1];
        end
    end

    // stages 1..7: degree search, one lane per marker
    logic [mpae_pkg::DegW-1:0] lane_deg [mpae_pkg::NMark];

    for (genvar m = 0; m < mpae_pkg::NMark; m++) begin : g_lane
        mpae_atan_lane u_lane (
            .i_clk (i_clk),
            .i_en  (rdy[mpae_pkg::NSearch:1]),
            .i_ax  (r0_ax[m]),
            .i_ay  (r0_ay[m]),
            .o_deg (lane_deg[m])
        );
    end

    // stage 8: bearing, offset removal and reduction to 0..359
    mpae_pkg::t_side sd;
    logic [9:0]      base [mpae_pkg::NMark];
    logic [9:0]      brg  [mpae_pkg::NMark];
    logic [10:0]     acc  [mpae_pkg::NMark];
    logic [8:0]      n8_ang [mpae_pkg::NMark];

    logic [8:0]                r8_ang [mpae_pkg::NMark];
    logic [mpae_pkg::NMark-1:0] r8_mask;
    logic                      r8_ok;

    always_comb begin
        sd = r_side[SBear-1];
        for (int m = 0; m < mpae_pkg::NMark; m++) begin
            base[m] = sd.dx_neg[m] ? 10'd270 : 10'd90;
            if (sd.dx_zero[m]) begin
                brg[m] = sd.dy_neg[m] ? 10'd180 : 10'd0;
            end else if (sd.dy_zero[m] || (sd.dx_neg[m] == sd.dy_neg[m])) begin
                brg[m] = base[m] + 10'(lane_deg[m]);
            end else if (sd.diag[m]) begin
                brg[m] = base[m] - 10'(lane_deg[m]);
            end else begin
                brg[m] = base[m] - 10'(lane_deg[m]) - 10'd1;
            end
            acc[m] = 11'(brg[m]) + 11'd720 - 11'(r_off[m]);
            if (acc[m] >= 11'd720) begin
                n8_ang[m] = 9'(acc[m] - 11'd720);
            end else if (acc[m] >= 11'd360) begin
                n8_ang[m] = 9'(acc[m] - 11'd360);
            end else begin
                n8_ang[m] = acc[m][8:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SBear]) begin
            r8_ang  <= n8_ang;
            r8_mask <= sd.mask;
            r8_ok   <= sd.ok;
        end
    end

    // stage 9: min, max and count of present angles
    logic [8:0] n9_mn;
    logic [8:0] n9_mx;
    logic [2:0] n9_n;

    logic [8:0]                r9_ang [mpae_pkg::NMark];
    logic [mpae_pkg::NMark-1:0] r9_mask;
    logic [8:0]                r9_mn;
    logic [8:0]                r9_mx;
    logic [2:0]                r9_n;
    logic                      r9_ok;

    always_comb begin
        n9_mn = 9'd359;
        n9_mx = 9'd0;
        n9_n  = 3'd0;
        for (int m = 0; m < mpae_pkg::NMark; m++) begin
            if (r8_mask[m]) begin
                if (r8_ang[m] < n9_mn) n9_mn = r8_ang[m];
                if (r8_ang[m] > n9_mx) n9_mx = r8_ang[m];
                n9_n = n9_n + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SMinMx]) begin
            r9_ang  <= r8_ang;
            r9_mask <= r8_mask;
            r9_mn   <= n9_mn;
            r9_mx   <= n9_mx;
            r9_n    <= n9_n;
            r9_ok   <= r8_ok;
        end
    end

    // stage 10: sum with wrap-around lift
    logic        wrap;
    logic [11:0] n10_sum;

    logic [11:0] r10_sum;
    logic [2:0]  r10_n;
    logic        r10_ok;

    always_comb begin
        wrap    = (r9_mx - r9_mn) > 9'd300;
        n10_sum = '0;
        for (int m = 0; m < mpae_pkg::NMark; m++) begin
            if (r9_mask[m]) begin
                if (wrap && (10'(r9_ang[m]) + 10'd300 < 10'(r9_mx))) begin
                    n10_sum = n10_sum + 12'(r9_ang[m]) + 12'd360;
                end else begin
                    n10_sum = n10_sum + 12'(r9_ang[m]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SSum]) begin
            r10_sum <= n10_sum;
            r10_n   <= r9_n;
            r10_ok  <= r9_ok;
        end
    end

    // stage 11: truncating divide by the count, fold above 180
    logic [27:0]        third;
    logic [11:0]        quo;
    logic signed [12:0] folded;

    logic signed [mpae_pkg::AngW-1:0] r11_angle;
    logic                             r11_valid;

    always_comb begin
        // divide by three through the reciprocal 21846 / 2^16, exact for these sums
        third = 28'(r10_sum) * 28'd21846;
        unique case (r10_n)
            3'd2:    quo = r10_sum >> 1;
            3'd3:    quo = third[27:16];
            3'd4:    quo = r10_sum >> 2;
            default: quo = r10_sum;
        endcase
        folded = (quo > 12'd180) ? $signed({1'b0, quo}) - 13'sd360 : $signed({1'b0, quo});
    end

    always_ff @(posedge i_clk) begin
        if (rdy[SOut]) begin
            r11_angle <= r10_ok ? folded[mpae_pkg::AngW-1:0] : '0;
            r11_valid <= r10_ok;
        end
    end

    assign o_m_tvalid = r_vld[SOut];
    assign o_m_tdata  = {7'd0, r11_angle};
    assign o_m_tuser  = r11_valid;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[8:0] == '0)
        else $error("invalid result carries a nonzero angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[8:0]) >= -9'sd179)
                    && ($signed(o_m_tdata[8:0]) <= 9'sd180))
        else $error("angle outside -179..180");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SMinMx] && r9_ok |-> r9_mx < 9'd360 && r9_n != 3'd0)
        else $error("reduced angle or count out of range");
`endif

endmodule
`default_nettype wire
